/* rtl/scheduled_zone_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scheduled zone sequencer
// Each macro expects i_clk and i_rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_ZONE_SEQUENCER_ASSERT_SVH
`define SCHEDULED_ZONE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SZS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("scheduled_zone_sequencer: check failed");

// next-cycle implication, checked outside reset
`define SZS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("scheduled_zone_sequencer: check failed");

`endif

/* rtl/szs_pkg.sv */
// ----------------------------------------------------------------------------
// szs_pkg
// Shared widths, register indexes and control types of the zone sequencer.
// ----------------------------------------------------------------------------
package szs_pkg;

    // zone and timer constants
    localparam int ZONE_COUNT       = 3;
    localparam int ZONE_W           = 2;
    localparam int ELAPSED_W        = 14;
    localparam int MINUTES_W        = 8;
    localparam int DAYS_PER_WEEK    = 7;

    // field widths
    localparam int HOUR_W           = 5;
    localparam int MINUTE_W         = 6;
    localparam int WDAY_W           = 3;

    // register port
    localparam int APB_AW           = 5;
    localparam int APB_DW           = 32;
    localparam int REG_IDX_W        = 3;

    localparam logic [REG_IDX_W-1:0] REG_START_HOUR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_MINUTE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DAY_MASK     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_ENABLE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZONE1_MIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ZONE2_MIN    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ZONE3_MIN    = 3'd6;

    // reset values
    localparam logic [HOUR_W-1:0] START_HOUR_RST = 5'd6;

    // saturation point of the zone timer
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // configuration seen by the datapath
    typedef struct packed {
        logic [HOUR_W-1:0]        start_hour;
        logic [MINUTE_W-1:0]      start_minute;
        logic [DAYS_PER_WEEK-1:0] day_mask;
        logic [ZONE_COUNT-1:0]    zone_enable;
        logic [MINUTES_W-1:0]     zone1_minutes;
        logic [MINUTES_W-1:0]     zone2_minutes;
        logic [MINUTES_W-1:0]     zone3_minutes;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic timer;
        logic walk_init;
        logic walk_step;
        logic sched;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic timer_adv;
        logic walk_end;
        logic walk_hit;
        logic sched_start;
    } t_stat;

    // minutes * 60 as (m << 6) - (m << 2)
    function automatic logic [ELAPSED_W-1:0] minutes_to_ticks(input logic [MINUTES_W-1:0] m);
        logic [ELAPSED_W-1:0] v64;
        logic [ELAPSED_W-1:0] v4;
        v64 = {m, 6'b0};
        v4  = {4'b0, m, 2'b0};
        return v64 - v4;
    endfunction

endpackage

/* rtl/szs_in_if.sv */
// ----------------------------------------------------------------------------
// szs_in_if
// Tick channel: wall-clock hour, minute and weekday with valid/ready.
// ----------------------------------------------------------------------------
interface szs_in_if;
    logic                        valid;
    logic                        ready;
    logic [szs_pkg::HOUR_W-1:0]   hour_now;
    logic [szs_pkg::MINUTE_W-1:0] minute_now;
    logic [szs_pkg::WDAY_W-1:0]   weekday_now;

    modport source (output valid, output hour_now, output minute_now, output weekday_now,
                    input ready);
    modport sink   (input valid, input hour_now, input minute_now, input weekday_now,
                    output ready);
endinterface

/* rtl/szs_out_if.sv */
// ----------------------------------------------------------------------------
// szs_out_if
// Result channel: relay drive and session status with valid/ready.
// ----------------------------------------------------------------------------
interface szs_out_if;
    logic                          valid;
    logic                          ready;
    logic [szs_pkg::ZONE_COUNT-1:0] relay_mask;
    logic                          running;
    logic [szs_pkg::ZONE_W-1:0]     zone_index;
    logic                          session_started;
    logic                          session_ended;

    modport source (output valid, output relay_mask, output running, output zone_index,
                    output session_started, output session_ended, input ready);
    modport sink   (input valid, input relay_mask, input running, input zone_index,
                    input session_started, input session_ended, output ready);
endinterface

/* rtl/szs_ctrl.sv */
// ----------------------------------------------------------------------------
// szs_ctrl
// Sequencing FSM: timer step, zone walk, schedule check, result hand-off.
// ----------------------------------------------------------------------------
module szs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  szs_pkg::t_stat i_stat,
    output szs_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TIMER = 5'b00010,
        S_WALK  = 5'b00100,
        S_SCHED = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_from_start, n_from_start;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_from_start = r_from_start;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_TIMER;
                end
            end
            S_TIMER: begin
                o_cmd.timer = 1'b1;
                if (i_stat.timer_adv) begin
                    o_cmd.walk_init = 1'b1;
                    n_from_start    = 1'b0;
                    n_state         = S_WALK;
                end else begin
                    n_state = S_SCHED;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_end || i_stat.walk_hit) begin
                    n_state = r_from_start ? S_DONE : S_SCHED;
                end
            end
            S_SCHED: begin
                o_cmd.sched = 1'b1;
                if (i_stat.sched_start) begin
                    n_from_start = 1'b1;
                    n_state      = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // output register free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_from_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_from_start <= n_from_start;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/szs_dpath.sv */
// ----------------------------------------------------------------------------
// szs_dpath
// Session state, zone timer, zone walk, schedule match and result register.
// ----------------------------------------------------------------------------
module szs_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  szs_pkg::t_cfg                  i_cfg,
    input  szs_pkg::t_cmd                  i_cmd,
    output szs_pkg::t_stat                 o_stat,
    input  logic [szs_pkg::HOUR_W-1:0]     i_hour_now,
    input  logic [szs_pkg::MINUTE_W-1:0]   i_minute_now,
    input  logic [szs_pkg::WDAY_W-1:0]     i_weekday_now,
    output logic [szs_pkg::ZONE_COUNT-1:0] o_relay_mask,
    output logic                           o_running,
    output logic [szs_pkg::ZONE_W-1:0]     o_zone_index,
    output logic                           o_session_started,
    output logic                           o_session_ended
);

    localparam logic [szs_pkg::ZONE_W-1:0] ZONE_END = szs_pkg::ZONE_W'(szs_pkg::ZONE_COUNT);

    // captured tick
    logic [szs_pkg::HOUR_W-1:0]    r_hour;
    logic [szs_pkg::MINUTE_W-1:0]  r_minute;
    logic [szs_pkg::WDAY_W-1:0]    r_wday;

    // session state
    logic                           r_active;
    logic [szs_pkg::ZONE_W-1:0]     r_zone;
    logic [szs_pkg::ELAPSED_W-1:0]  r_elapsed;
    logic                           r_stm;
    logic [szs_pkg::MINUTES_W-1:0]  r_lat [szs_pkg::ZONE_COUNT];
    logic [szs_pkg::ELAPSED_W-1:0]  r_limit;
    logic [szs_pkg::ZONE_W-1:0]     r_walk;
    logic                           r_started;
    logic                           r_ended;

    // result register
    logic [szs_pkg::ZONE_COUNT-1:0] r_relay;
    logic                           r_running;
    logic [szs_pkg::ZONE_W-1:0]     r_zidx;
    logic                           r_sst;
    logic                           r_send;

    logic [szs_pkg::ELAPSED_W-1:0]  w_inc;
    logic [szs_pkg::MINUTES_W-1:0]  w_walk_min;
    logic                           w_time_match;
    logic                           w_day_ok;
    logic [szs_pkg::DAYS_PER_WEEK:0] w_day_ext;
    logic [szs_pkg::WDAY_W-1:0]     w_day_idx;

    // saturating tick count
    assign w_inc = (r_elapsed == szs_pkg::ELAPSED_MAX) ? r_elapsed
                 : r_elapsed + szs_pkg::ELAPSED_W'(1);

    // latched duration at the walk pointer
    always_comb begin
        case (r_walk)
            2'd0:    w_walk_min = r_lat[0];
            2'd1:    w_walk_min = r_lat[1];
            2'd2:    w_walk_min = r_lat[2];
            default: w_walk_min = '0;
        endcase
    end

    // schedule match; weekday 0 maps onto the zero pad bit
    assign w_time_match = (r_hour == i_cfg.start_hour) && (r_minute == i_cfg.start_minute);
    assign w_day_ext    = {1'b0, i_cfg.day_mask};
    assign w_day_idx    = r_wday - szs_pkg::WDAY_W'(1);
    assign w_day_ok     = (r_wday != '0) && w_day_ext[w_day_idx];

    assign o_stat.timer_adv   = r_active && (w_inc >= r_limit);
    assign o_stat.walk_end    = (r_walk == ZONE_END);
    assign o_stat.walk_hit    = (r_walk != ZONE_END) && (w_walk_min != '0);
    assign o_stat.sched_start = !r_active && w_time_match && !r_stm && w_day_ok
                              && (i_cfg.zone_enable != '0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_zone    <= '0;
            r_elapsed <= '0;
            r_stm     <= 1'b0;
            r_walk    <= '0;
            r_started <= 1'b0;
            r_ended   <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_started <= 1'b0;
                r_ended   <= 1'b0;
            end
            if (i_cmd.timer && r_active) begin
                r_elapsed <= w_inc;
            end
            if (i_cmd.walk_init) begin
                r_walk <= r_zone + szs_pkg::ZONE_W'(1);
            end
            // one zone per step
            if (i_cmd.walk_step) begin
                if (r_walk == ZONE_END) begin
                    r_active  <= 1'b0;
                    r_zone    <= '0;
                    r_elapsed <= '0;
                    r_ended   <= 1'b1;
                end else if (w_walk_min != '0) begin
                    r_zone    <= r_walk;
                    r_elapsed <= '0;
                end else begin
                    r_walk <= r_walk + szs_pkg::ZONE_W'(1);
                end
            end
            // schedule check, idle only
            if (i_cmd.sched && !r_active) begin
                if (!w_time_match) begin
                    r_stm <= 1'b0;
                end else if (!r_stm && w_day_ok) begin
                    r_stm <= 1'b1;
                    if (i_cfg.zone_enable != '0) begin
                        r_active  <= 1'b1;
                        r_started <= 1'b1;
                        r_walk    <= '0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_hour   <= i_hour_now;
            r_minute <= i_minute_now;
            r_wday   <= i_weekday_now;
        end
        if (i_cmd.walk_step && (r_walk != ZONE_END) && (w_walk_min != '0)) begin
            r_limit <= szs_pkg::minutes_to_ticks(w_walk_min);
        end
        if (o_stat.sched_start && i_cmd.sched) begin
            r_lat[0] <= i_cfg.zone_enable[0] ? i_cfg.zone1_minutes : '0;
            r_lat[1] <= i_cfg.zone_enable[1] ? i_cfg.zone2_minutes : '0;
            r_lat[2] <= i_cfg.zone_enable[2] ? i_cfg.zone3_minutes : '0;
        end
        if (i_cmd.load_out) begin
            r_relay   <= r_active ? szs_pkg::ZONE_COUNT'(3'b001 << r_zone) : '0;
            r_running <= r_active;
            r_zidx    <= r_active ? r_zone : '0;
            r_sst     <= r_started;
            r_send    <= r_ended;
        end
    end

    assign o_relay_mask      = r_relay;
    assign o_running         = r_running;
    assign o_zone_index      = r_zidx;
    assign o_session_started = r_sst;
    assign o_session_ended   = r_send;

endmodule

/* rtl/scheduled_zone_sequencer.sv */
// ----------------------------------------------------------------------------
// scheduled_zone_sequencer
// Three-zone watering sequencer driven by one-second wall-clock ticks.
// ----------------------------------------------------------------------------
// One item is worked at a time. A tick is accepted in the idle cycle. With no
// zone change it then passes the timer, schedule and done states, and its
// result is loaded into the output register at the edge that ends the done
// state. A zone change walks the later zones one per cycle, and a session
// start walks from the first zone. The done state waits while the previous
// result is still held on the output side. A new tick is accepted while that
// previous result still waits. Configuration registers sit on the APB port;
// durations are copied at session start, so writes during a session act on
// the next one.
module scheduled_zone_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    szs_in_if.sink                       i_in,
    szs_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [szs_pkg::APB_AW-1:0]   paddr,
    input  logic [szs_pkg::APB_DW-1:0]   pwdata,
    output logic [szs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    szs_pkg::t_cfg  r_cfg;
    szs_pkg::t_cmd  w_cmd;
    szs_pkg::t_stat w_stat;

    logic [szs_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[szs_pkg::APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_hour    <= szs_pkg::START_HOUR_RST;
            r_cfg.start_minute  <= '0;
            r_cfg.day_mask      <= '0;
            r_cfg.zone_enable   <= '0;
            r_cfg.zone1_minutes <= '0;
            r_cfg.zone2_minutes <= '0;
            r_cfg.zone3_minutes <= '0;
        end else if (w_wr) begin
            case (w_idx)
                szs_pkg::REG_START_HOUR:
                    r_cfg.start_hour    <= pwdata[szs_pkg::HOUR_W-1:0];
                szs_pkg::REG_START_MINUTE:
                    r_cfg.start_minute  <= pwdata[szs_pkg::MINUTE_W-1:0];
                szs_pkg::REG_DAY_MASK:
                    r_cfg.day_mask      <= pwdata[szs_pkg::DAYS_PER_WEEK-1:0];
                szs_pkg::REG_ZONE_ENABLE:
                    r_cfg.zone_enable   <= pwdata[szs_pkg::ZONE_COUNT-1:0];
                szs_pkg::REG_ZONE1_MIN:
                    r_cfg.zone1_minutes <= pwdata[szs_pkg::MINUTES_W-1:0];
                szs_pkg::REG_ZONE2_MIN:
                    r_cfg.zone2_minutes <= pwdata[szs_pkg::MINUTES_W-1:0];
                szs_pkg::REG_ZONE3_MIN:
                    r_cfg.zone3_minutes <= pwdata[szs_pkg::MINUTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            szs_pkg::REG_START_HOUR:   prdata = szs_pkg::APB_DW'(r_cfg.start_hour);
            szs_pkg::REG_START_MINUTE: prdata = szs_pkg::APB_DW'(r_cfg.start_minute);
            szs_pkg::REG_DAY_MASK:     prdata = szs_pkg::APB_DW'(r_cfg.day_mask);
            szs_pkg::REG_ZONE_ENABLE:  prdata = szs_pkg::APB_DW'(r_cfg.zone_enable);
            szs_pkg::REG_ZONE1_MIN:    prdata = szs_pkg::APB_DW'(r_cfg.zone1_minutes);
            szs_pkg::REG_ZONE2_MIN:    prdata = szs_pkg::APB_DW'(r_cfg.zone2_minutes);
            szs_pkg::REG_ZONE3_MIN:    prdata = szs_pkg::APB_DW'(r_cfg.zone3_minutes);
            default:                   prdata = '0;
        endcase
    end

    szs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    szs_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_hour_now        (i_in.hour_now),
        .i_minute_now      (i_in.minute_now),
        .i_weekday_now     (i_in.weekday_now),
        .o_relay_mask      (o_out.relay_mask),
        .o_running         (o_out.running),
        .o_zone_index      (o_out.zone_index),
        .o_session_started (o_out.session_started),
        .o_session_ended   (o_out.session_ended)
    );

endmodule

/* rtl/szs_checker.sv */
// ----------------------------------------------------------------------------
// szs_checker
// Port-level checks on the result channel of the zone sequencer.
// ----------------------------------------------------------------------------
`include "scheduled_zone_sequencer_assert.svh"

module szs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [szs_pkg::ZONE_COUNT-1:0] i_relay_mask,
    input logic                           i_running,
    input logic [szs_pkg::ZONE_W-1:0]     i_zone_index,
    input logic                           i_session_started,
    input logic                           i_session_ended
);

    // idle result drives no relay
    `SZS_ASSERT_SAME(a_idle_quiet, i_out_valid && !i_running,
        (i_relay_mask == '0) && (i_zone_index == '0))

    // relay drive matches the reported zone
    `SZS_ASSERT_SAME(a_relay_zone, i_out_valid && i_running,
        ((i_zone_index == 2'd0) && (i_relay_mask == 3'b001)) ||
        ((i_zone_index == 2'd1) && (i_relay_mask == 3'b010)) ||
        ((i_zone_index == 2'd2) && (i_relay_mask == 3'b100)))

    // a start that does not end at once leaves a zone running
    `SZS_ASSERT_SAME(a_start_runs, i_out_valid && i_session_started && !i_session_ended,
        i_running)

    // an end without a restart leaves the block idle
    `SZS_ASSERT_SAME(a_end_idle, i_out_valid && i_session_ended && !i_session_started,
        !i_running)

    // a stalled result holds
    `SZS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_relay_mask, i_running, i_zone_index,
                                i_session_started, i_session_ended}))

endmodule

bind scheduled_zone_sequencer szs_checker u_szs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_relay_mask      (o_out.relay_mask),
    .i_running         (o_out.running),
    .i_zone_index      (o_out.zone_index),
    .i_session_started (o_out.session_started),
    .i_session_ended   (o_out.session_ended)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scheduled zone sequencer. A short table of ticks
// and register writes walks the corner cases of the scheduler (unused start
// minute, restart lock, empty sessions, bad weekday, off-range clock values,
// writes during a session). Random phases then program a fresh schedule and
// play a wall clock around the start minute, with some noise items. An
// in-bench behavioral copy of the sequencer predicts the status of every tick.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_MIN = 60;
    localparam int ITEMS         = 1750;
    localparam int FINAL_LEN     = 250;
    localparam int IDLE_PCT      = 25;
    // stretches with no idling, in items sent and in results taken
    localparam int CALM_LO       = 500;
    localparam int CALM_HI       = 800;
    localparam int CALM_RES_LO   = 1000;
    localparam int CALM_RES_HI   = 1300;
    // long output hold-off
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int DIR_ROWS      = 27;

    // address past the register map
    localparam logic [szs_pkg::REG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [szs_pkg::ZONE_COUNT-1:0] relay;
        logic                           run;
        logic [szs_pkg::ZONE_W-1:0]     zone;
        logic                           started;
        logic                           ended;
    } t_status;

    typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_TICK_EXP} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [szs_pkg::REG_IDX_W-1:0] reg_idx;
        logic [7:0]                    wdata;
        logic [szs_pkg::HOUR_W-1:0]    hour;
        logic [szs_pkg::MINUTE_W-1:0]  minute;
        logic [szs_pkg::WDAY_W-1:0]    wday;
        t_status                       want;
    } t_dir_row;

    localparam t_status ST_IDLE      = '{3'b000, 1'b0, 2'd0, 1'b0, 1'b0};
    localparam t_status ST_EMPTY_RUN = '{3'b000, 1'b0, 2'd0, 1'b1, 1'b1};
    localparam t_status ST_Z1_START  = '{3'b010, 1'b1, 2'd1, 1'b1, 1'b0};

    // directed part: typed expectations only where obvious
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // reset schedule 06:00, no day enabled
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd1, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_DAY_MASK,     8'h01,  5'd0,  6'd0,  3'd0, ST_IDLE},
        // no zone enabled: minute is used up, nothing runs
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd1, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_ZONE_ENABLE,  8'h07,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd1, ST_IDLE},
        '{ROW_TICK,     REG_NONE,                  8'd0,   5'd6,  6'd1,  3'd1, ST_IDLE},
        // all durations zero: start and end on one tick
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd1, ST_EMPTY_RUN},
        // ended, but the minute lock holds
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd1, ST_IDLE},
        '{ROW_TICK,     REG_NONE,                  8'd0,   5'd7,  6'd0,  3'd1, ST_IDLE},
        // invalid weekday, then a disabled day
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd2, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_DAY_MASK,     8'h40,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd6,  6'd0,  3'd7, ST_EMPTY_RUN},
        // off-range start time compared as is; a near miss clears the lock
        '{ROW_WRITE,    szs_pkg::REG_START_HOUR,   8'd31,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_START_MINUTE, 8'd63,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK,     REG_NONE,                  8'd0,   5'd31, 6'd62, 3'd7, ST_IDLE},
        '{ROW_WRITE,    REG_NONE,                  8'hFF,  5'd0,  6'd0,  3'd0, ST_IDLE},
        // 23:59 start, only zone two enabled, disabled zones at 255
        '{ROW_WRITE,    szs_pkg::REG_START_HOUR,   8'd23,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_START_MINUTE, 8'd59,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_ZONE1_MIN,    8'd255, 5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_ZONE3_MIN,    8'd255, 5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_ZONE2_MIN,    8'd1,   5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_WRITE,    szs_pkg::REG_ZONE_ENABLE,  8'h02,  5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK_EXP, REG_NONE,                  8'd0,   5'd23, 6'd59, 3'd7, ST_Z1_START},
        // write during the session must not touch the latched time
        '{ROW_WRITE,    szs_pkg::REG_ZONE2_MIN,    8'd0,   5'd0,  6'd0,  3'd0, ST_IDLE},
        '{ROW_TICK,     REG_NONE,                  8'd0,   5'd23, 6'd59, 3'd7, ST_IDLE},
        '{ROW_TICK,     REG_NONE,                  8'd0,   5'd0,  6'd0,  3'd1, ST_IDLE}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [szs_pkg::APB_AW-1:0]   paddr;
    logic [szs_pkg::APB_DW-1:0]   pwdata;
    logic [szs_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    szs_in_if  tick_if ();
    szs_out_if res_if ();

    scheduled_zone_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench bookkeeping
    t_status status_due [$];
    int      errors       = 0;
    int      sent_total   = 0;
    int      results_seen = 0;
    bit      hold_done    = 1'b0;

    // behavioral sequencer state
    szs_pkg::t_cfg                 cfg;
    logic                          sess_on;
    logic [szs_pkg::ZONE_W-1:0]    cur_zone;
    logic [szs_pkg::ELAPSED_W-1:0] zone_ticks;
    logic                          fired_in_minute;
    logic [szs_pkg::MINUTES_W-1:0] held_min [szs_pkg::ZONE_COUNT];

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("ERROR %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // move to the first zone at or after 'first' with a nonzero latched time;
    // returns 1 when the session runs out of zones
    function automatic bit seek_zone(input int first);
        for (int z = first; z < szs_pkg::ZONE_COUNT; z++) begin
            if (held_min[z] != '0) begin
                cur_zone   = szs_pkg::ZONE_W'(z);
                zone_ticks = '0;
                return 1'b0;
            end
        end
        sess_on    = 1'b0;
        cur_zone   = '0;
        zone_ticks = '0;
        return 1'b1;
    endfunction

    // one-second tick: zone timer first, then the schedule when idle
    function automatic t_status tick_outcome(input logic [szs_pkg::HOUR_W-1:0] h,
                                             input logic [szs_pkg::MINUTE_W-1:0] m,
                                             input logic [szs_pkg::WDAY_W-1:0] d);
        t_status                       st;
        int                            limit;
        logic [szs_pkg::MINUTES_W-1:0] cfg_min [szs_pkg::ZONE_COUNT];
        logic                          began;
        logic                          finished;
        began      = 1'b0;
        finished   = 1'b0;
        cfg_min[0] = cfg.zone1_minutes;
        cfg_min[1] = cfg.zone2_minutes;
        cfg_min[2] = cfg.zone3_minutes;
        if (sess_on) begin
            limit = int'(held_min[cur_zone]) * TICKS_PER_MIN;
            if (zone_ticks != szs_pkg::ELAPSED_MAX) zone_ticks = zone_ticks + 1'b1;
            if (int'(zone_ticks) >= limit) finished = seek_zone(int'(cur_zone) + 1);
        end
        if (!sess_on) begin
            if (h != cfg.start_hour || m != cfg.start_minute) begin
                fired_in_minute = 1'b0;
            end else if (!fired_in_minute && d != '0 && cfg.day_mask[d - 1'b1]) begin
                fired_in_minute = 1'b1;
                if (cfg.zone_enable != '0) begin
                    for (int z = 0; z < szs_pkg::ZONE_COUNT; z++)
                        held_min[z] = cfg.zone_enable[z] ? cfg_min[z] : '0;
                    sess_on = 1'b1;
                    began   = 1'b1;
                    if (seek_zone(0)) finished = 1'b1;
                end
            end
        end
        if (sess_on) begin
            st.relay = szs_pkg::ZONE_COUNT'(1) << cur_zone;
            st.run   = 1'b1;
            st.zone  = cur_zone;
        end else begin
            st.relay = '0;
            st.run   = 1'b0;
            st.zone  = '0;
        end
        st.started = began;
        st.ended   = finished;
        return st;
    endfunction

    function automatic void apply_reg_write(input logic [szs_pkg::REG_IDX_W-1:0] idx,
                                            input logic [31:0] data);
        case (idx)
            szs_pkg::REG_START_HOUR:   cfg.start_hour    = data[szs_pkg::HOUR_W-1:0];
            szs_pkg::REG_START_MINUTE: cfg.start_minute  = data[szs_pkg::MINUTE_W-1:0];
            szs_pkg::REG_DAY_MASK:     cfg.day_mask      = data[szs_pkg::DAYS_PER_WEEK-1:0];
            szs_pkg::REG_ZONE_ENABLE:  cfg.zone_enable   = data[szs_pkg::ZONE_COUNT-1:0];
            szs_pkg::REG_ZONE1_MIN:    cfg.zone1_minutes = data[szs_pkg::MINUTES_W-1:0];
            szs_pkg::REG_ZONE2_MIN:    cfg.zone2_minutes = data[szs_pkg::MINUTES_W-1:0];
            szs_pkg::REG_ZONE3_MIN:    cfg.zone3_minutes = data[szs_pkg::MINUTES_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_now(input logic [szs_pkg::REG_IDX_W-1:0] idx);
        case (idx)
            szs_pkg::REG_START_HOUR:   return 32'(cfg.start_hour);
            szs_pkg::REG_START_MINUTE: return 32'(cfg.start_minute);
            szs_pkg::REG_DAY_MASK:     return 32'(cfg.day_mask);
            szs_pkg::REG_ZONE_ENABLE:  return 32'(cfg.zone_enable);
            szs_pkg::REG_ZONE1_MIN:    return 32'(cfg.zone1_minutes);
            szs_pkg::REG_ZONE2_MIN:    return 32'(cfg.zone2_minutes);
            szs_pkg::REG_ZONE3_MIN:    return 32'(cfg.zone3_minutes);
            default:                   return '0;
        endcase
    endfunction

    // APB write, then read back (mapped registers only)
    task automatic reg_write(input logic [szs_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        if (idx == REG_NONE) begin
            psel    = 1'b0;
            penable = 1'b0;
        end else begin
            penable = 1'b0;
            pwrite  = 1'b0;
            @(negedge i_clk);
            penable = 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== reg_now(idx)) flag_error("register readback", prdata, reg_now(idx));
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    // offer one tick item; predict its status once accepted
    task automatic send_tick(input logic [szs_pkg::HOUR_W-1:0] h,
                             input logic [szs_pkg::MINUTE_W-1:0] m,
                             input logic [szs_pkg::WDAY_W-1:0] d, input bit typed,
                             input t_status typed_st);
        t_status calc;
        @(negedge i_clk);
        while (!(sent_total >= CALM_LO && sent_total < CALM_HI) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            tick_if.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_if.valid       = 1'b1;
        tick_if.hour_now    = h;
        tick_if.minute_now  = m;
        tick_if.weekday_now = d;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        calc = tick_outcome(h, m, d);
        status_due.push_back(typed ? typed_st : calc);
        sent_total++;
    endtask

    // stop offering and wait for every pending status
    task automatic wait_drained();
        @(negedge i_clk);
        tick_if.valid = 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    // one random phase: new schedule, then a wall clock around the start minute
    task automatic run_phase(input int len_min, input int len_max, input bit long_run);
        logic [szs_pkg::HOUR_W-1:0]        hr;
        logic [szs_pkg::HOUR_W-1:0]        cur_h;
        logic [szs_pkg::MINUTE_W-1:0]      mn;
        logic [szs_pkg::MINUTE_W-1:0]      cur_m;
        logic [szs_pkg::WDAY_W-1:0]        day;
        logic [szs_pkg::DAYS_PER_WEEK-1:0] mask;
        logic [szs_pkg::ZONE_COUNT-1:0]    en;
        logic [szs_pkg::MINUTES_W-1:0]     mins [szs_pkg::ZONE_COUNT];
        logic [31:0]                       rnd;
        int                                sec;
        int                                r;
        int                                n;
        wait_drained();
        hr  = (long_run || $urandom_range(0, 9) != 0)
              ? szs_pkg::HOUR_W'($urandom_range(0, 23))
              : szs_pkg::HOUR_W'($urandom_range(24, 31));
        mn  = (long_run || $urandom_range(0, 9) != 0)
              ? szs_pkg::MINUTE_W'($urandom_range(0, 59))
              : szs_pkg::MINUTE_W'($urandom_range(60, 63));
        day = szs_pkg::WDAY_W'($urandom_range(1, 7));
        r    = $urandom_range(0, 99);
        mask = szs_pkg::DAYS_PER_WEEK'($urandom_range(0, 127));
        if (r < 12) mask = '1;
        else if (r < 20) mask = '0;
        else if (r < 80) mask[day - 1'b1] = 1'b1;
        if (long_run) mask[day - 1'b1] = 1'b1;
        en = szs_pkg::ZONE_COUNT'($urandom_range(0, 7));
        // enabled zones run short; disabled ones hold any value
        for (int z = 0; z < szs_pkg::ZONE_COUNT; z++) begin
            r = $urandom_range(0, 99);
            if (!en[z]) mins[z] = szs_pkg::MINUTES_W'($urandom_range(0, 255));
            else mins[z] = (r < 20) ? 8'd0 : (r < 80) ? 8'd1 : 8'd2;
        end
        if (long_run) begin
            en[2]   = 1'b1;
            mins[2] = 8'd255;
        end

        // unused upper data bits carry noise
        rnd = $urandom();
        reg_write(szs_pkg::REG_START_HOUR,   {rnd[31:szs_pkg::HOUR_W], hr});
        reg_write(szs_pkg::REG_START_MINUTE, {rnd[31:szs_pkg::MINUTE_W], mn});
        reg_write(szs_pkg::REG_DAY_MASK,     {rnd[31:szs_pkg::DAYS_PER_WEEK], mask});
        reg_write(szs_pkg::REG_ZONE_ENABLE,  {rnd[31:szs_pkg::ZONE_COUNT], en});
        reg_write(szs_pkg::REG_ZONE1_MIN,    {rnd[31:szs_pkg::MINUTES_W], mins[0]});
        reg_write(szs_pkg::REG_ZONE2_MIN,    {rnd[31:szs_pkg::MINUTES_W], mins[1]});
        reg_write(szs_pkg::REG_ZONE3_MIN,    {rnd[31:szs_pkg::MINUTES_W], mins[2]});

        cur_h = hr;
        cur_m = mn;
        if (!long_run && $urandom_range(0, 1) != 0) begin
            if (cur_m == '0) begin
                cur_m = 6'd59;
                cur_h = (cur_h == '0) ? 5'd23 : cur_h - 1'b1;
            end else begin
                cur_m = cur_m - 1'b1;
            end
        end
        sec = $urandom_range(0, TICKS_PER_MIN - 1);

        for (n = 0; n < len_max; n++) begin
            if (n >= len_min && !sess_on) break;
            if (sent_total % 400 == 200) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_tick(szs_pkg::HOUR_W'($urandom()), szs_pkg::MINUTE_W'($urandom()),
                          szs_pkg::WDAY_W'($urandom()), 1'b0, ST_IDLE);
            end else if (r < 12) begin
                send_tick(cur_h, cur_m, szs_pkg::WDAY_W'($urandom_range(0, 7)), 1'b0,
                          ST_IDLE);
            end else begin
                send_tick(cur_h, cur_m, day, 1'b0, ST_IDLE);
            end
            // rare jump back to the start minute, else the clock runs on
            if (r == 99) begin
                cur_h = hr;
                cur_m = mn;
                sec   = 0;
            end else begin
                sec++;
                if (sec == TICKS_PER_MIN) begin
                    sec = 0;
                    if (cur_m >= 6'd59) begin
                        cur_m = '0;
                        cur_h = (cur_h >= 5'd23) ? '0 : cur_h + 1'b1;
                    end else begin
                        cur_m = cur_m + 1'b1;
                    end
                end
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            t_status want;
            results_seen++;
            if (status_due.size() == 0) begin
                flag_error("result with nothing pending", '0, '0);
            end else begin
                want = status_due.pop_front();
                if (res_if.relay_mask !== want.relay)
                    flag_error("relay_mask", res_if.relay_mask, want.relay);
                if (res_if.running !== want.run)
                    flag_error("running", res_if.running, want.run);
                if (res_if.zone_index !== want.zone)
                    flag_error("zone_index", res_if.zone_index, want.zone);
                if (res_if.session_started !== want.started)
                    flag_error("session_started", res_if.session_started, want.started);
                if (res_if.session_ended !== want.ended)
                    flag_error("session_ended", res_if.session_ended, want.ended);
            end
        end
    end

    // result side: random stalls, one long hold-off, one calm stretch
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done    = 1'b1;
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_if.ready = (results_seen >= CALM_RES_LO && results_seen < CALM_RES_HI) ||
                           ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // main stimulus
    initial begin
        t_dir_row row;
        tick_if.valid       = 1'b0;
        tick_if.hour_now    = '0;
        tick_if.minute_now  = '0;
        tick_if.weekday_now = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;

        cfg             = '0;
        cfg.start_hour  = szs_pkg::START_HOUR_RST;
        sess_on         = 1'b0;
        cur_zone        = '0;
        zone_ticks      = '0;
        fired_in_minute = 1'b0;
        foreach (held_min[z]) held_min[z] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_WRITE: begin
                    wait_drained();
                    reg_write(row.reg_idx, {24'h0, row.wdata});
                end
                ROW_TICK:     send_tick(row.hour, row.minute, row.wday, 1'b0, ST_IDLE);
                ROW_TICK_EXP: send_tick(row.hour, row.minute, row.wday, 1'b1, row.want);
                default: ;
            endcase
        end

        // random phases, last one with a long zone
        while (sent_total < ITEMS - FINAL_LEN) run_phase(60, 420, 1'b0);
        run_phase(FINAL_LEN, FINAL_LEN, 1'b1);

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
